// ----- rtl/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the frustum sphere cull block.
// ----------------------------------------------------------------------------
package fsc_pkg;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam int PLANE_COUNT = 6;

    // plane p: 1 = row3 + row k, 0 = row3 - row k (k = p / 2)
    localparam logic [PLANE_COUNT-1:0] PLANE_ADD = 6'b011001;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD,
        S_B_RAW,
        S_B_MUL,
        S_B_ACC,
        S_B_ROOT,
        S_B_ROOTW,
        S_B_DIV,
        S_B_DIVW,
        S_T_RD,
        S_T_MUL,
        S_T_ACC,
        S_T_RDD,
        S_T_CHK,
        S_T_OUT
    } t_state;

    typedef enum logic {
        RD_ROOT,
        RD_DIV
    } t_rd_mode;

    typedef struct packed {
        logic     start;
        t_rd_mode mode;
    } t_rd_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rd_sts;

endpackage

// ----- rtl/fsc_mul.sv -----
// ----------------------------------------------------------------------------
// fsc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fsc_mul #(
    parameter int AB = 33
) (
    input  logic                   i_clk,
    input  logic signed [AB-1:0]   i_a,
    input  logic signed [AB-1:0]   i_b,
    output logic signed [2*AB-1:0] o_p
);

    logic signed [2*AB-1:0] r_p;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- rtl/fsc_rdiv.sv -----
// ----------------------------------------------------------------------------
// fsc_rdiv
// Bit-serial root and divide unit: one shared compare/subtract per cycle.
// ----------------------------------------------------------------------------
module fsc_rdiv
    import fsc_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rd_ctl           i_ctl,
    output t_rd_sts           o_sts,
    input  logic [2*W+1:0]    i_sq,
    input  logic [W+F-1:0]    i_num,
    input  logic [W:0]        i_den,
    output logic [W:0]        o_root,
    output logic [W+F-1:0]    o_quot
);

    localparam int R    = W + 1;
    localparam int N    = W + F;
    localparam int SB   = 2 * R;
    localparam int XB   = (SB > N) ? SB : N;
    localparam int CB   = R + 4;
    localparam int IT   = (R > N) ? R : N;
    localparam int CNTW = $clog2(IT + 1);

    logic            r_busy;
    logic            r_done;
    t_rd_mode        r_mode;
    logic [CNTW-1:0] r_cnt;
    logic [XB-1:0]   r_x;
    logic [CB-1:0]   r_rem;
    logic [R-1:0]    r_root;

    logic [CB-1:0]   cand;
    logic [CB-1:0]   trial;
    logic [CB:0]     diff;
    logic            ge;

    // shared compare/subtract
    always_comb begin
        if (r_mode == RD_ROOT) begin
            cand  = {r_rem[CB-3:0], r_x[XB-1 -: 2]};
            trial = {{(CB-R-2){1'b0}}, r_root, 2'b01};
        end else begin
            cand  = {r_rem[CB-2:0], r_x[N-1]};
            trial = {{(CB-R){1'b0}}, i_den};
        end
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = !diff[CB];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_mode <= i_ctl.mode;
            r_rem  <= '0;
            r_root <= '0;
            if (i_ctl.mode == RD_ROOT) begin
                r_x   <= XB'(i_sq) << (XB - SB);
                r_cnt <= CNTW'(R);
            end else begin
                r_x   <= XB'(i_num);
                r_cnt <= CNTW'(N);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            r_rem <= ge ? diff[CB-1:0] : cand;
            if (r_mode == RD_ROOT) begin
                r_root <= {r_root[R-2:0], ge};
                r_x    <= r_x << 2;
            end else begin
                r_x <= {r_x[XB-2:0], ge};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_root;
    assign o_quot     = r_x[N-1:0];

endmodule

// ----- rtl/frustum_sphere_cull.sv -----
// ----------------------------------------------------------------------------
// frustum_sphere_cull
// Sphere-against-frustum cull: planes built from a loaded matrix, then
// sphere requests tested against all six planes.
// ----------------------------------------------------------------------------
//  channel | valid       | ready       | payload
//  in      | i_in_valid  | o_in_ready  | i_operation, i_column, i_m_row*, i_pos_*, i_radius
//  out     | o_out_valid | i_out_ready | o_inside_res
//
//  Column load: loading column 3 also starts a plane build whose run is set
//  by the bit-serial root/divide unit; a plane whose normal has zero length
//  skips its divides.
//  Sphere test: its run is set by the shared multiplier, three products per
//  plane, plus output handoff.
//  Reset clears matrix and plane stores through valid bits, no sweep.
//  Input is taken only in idle; a stalled output holds the next test result.
// ----------------------------------------------------------------------------
module frustum_sphere_cull
    import fsc_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [1:0]                  i_column,
    input  logic signed [WORD_BITS-1:0] i_m_row0,
    input  logic signed [WORD_BITS-1:0] i_m_row1,
    input  logic signed [WORD_BITS-1:0] i_m_row2,
    input  logic signed [WORD_BITS-1:0] i_m_row3,
    input  logic signed [WORD_BITS-1:0] i_pos_x,
    input  logic signed [WORD_BITS-1:0] i_pos_y,
    input  logic signed [WORD_BITS-1:0] i_pos_z,
    input  logic signed [WORD_BITS-1:0] i_radius,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_inside_res
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int N  = W + F;
    localparam int PW = 2 * W + 2;
    localparam int AW = 2 * W + 3;
    localparam logic [2:0] P_LAST = 3'(PLANE_COUNT - 1);
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    // control registers
    t_state          r_state, n_state;
    logic [2:0]      r_p, n_p;
    logic [1:0]      r_j, n_j;
    logic [3:0]      r_mat_vld;
    logic            r_pl_vld, n_pl_vld;
    logic            r_out_valid, n_out_valid;
    logic            r_inside_res, n_inside_res;

    // payload registers
    logic [W-1:0]    r_raw [0:3];
    logic [W-1:0]    n_raw_val;
    logic            raw_we;
    logic [PW-1:0]   r_sq, n_sq;
    logic [W:0]      r_len, n_len;
    logic signed [AW-1:0] r_acc, n_acc;
    logic            r_inside, n_inside;
    logic [W-1:0]    r_pos [0:2];
    logic [W-1:0]    r_rad;

    // memories
    logic [4*W-1:0]  r_mat [0:3];
    logic [4*W-1:0]  r_mat_rd;
    logic            r_mat_rd_v;
    logic [W-1:0]    r_pl [0:23];
    logic [W-1:0]    r_pl_rd;
    logic            pl_we;
    logic [W-1:0]    pl_wd;

    // shared units
    logic signed [W:0]    mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    t_rd_ctl              rd_ctl;
    t_rd_sts              rd_sts;
    logic [W:0]           rd_root;
    logic [N-1:0]         rd_quot;

    // helpers
    logic            accept;
    logic [W-1:0]    cur_raw, mag_j, r3, rk, pl_eff, pos_j, sat_val, q_lo;
    logic [W:0]      sum_w;
    logic            q_big;
    logic signed [AW-1:0] tot;

    assign accept = i_in_valid && o_in_ready;

    fsc_mul #(.AB(W + 1)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    fsc_rdiv #(.W(W), .F(F)) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rd_ctl),
        .o_sts   (rd_sts),
        .i_sq    (r_sq),
        .i_num   ({mag_j, {F{1'b0}}}),
        .i_den   (r_len),
        .o_root  (rd_root),
        .o_quot  (rd_quot)
    );

    // matrix store: one entry per column holding all four rows, read by column index
    always_ff @(posedge i_clk) begin
        if (accept && i_operation == OP_LOAD) begin
            r_mat[i_column] <= {i_m_row3, i_m_row2, i_m_row1, i_m_row0};
        end
        r_mat_rd   <= r_mat[r_j];
        r_mat_rd_v <= r_mat_vld[r_j];
    end

    // plane store
    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            r_pl[{r_p, r_j}] <= pl_wd;
        end
        r_pl_rd <= r_pl[{r_p, r_j}];
    end

    // operand selection and arithmetic
    always_comb begin
        cur_raw = r_raw[r_j];
        mag_j   = cur_raw[W-1] ? (~cur_raw + W'(1)) : cur_raw;
        r3      = r_mat_rd_v ? r_mat_rd[3*W +: W] : '0;
        rk      = r_mat_rd_v ? r_mat_rd[r_p[2:1]*W +: W] : '0;
        if (PLANE_ADD[r_p]) begin
            sum_w = {r3[W-1], r3} + {rk[W-1], rk};
        end else begin
            sum_w = {r3[W-1], r3} - {rk[W-1], rk};
        end
        if (sum_w[W] != sum_w[W-1]) begin
            sat_val = sum_w[W] ? WMIN : WMAX;
        end else begin
            sat_val = sum_w[W-1:0];
        end
        pl_eff = r_pl_vld ? r_pl_rd : '0;
        case (r_j)
            2'd0:    pos_j = r_pos[0];
            2'd1:    pos_j = r_pos[1];
            default: pos_j = r_pos[2];
        endcase
        q_big = |rd_quot[N-1:W-1];
        q_lo  = rd_quot[W-1:0];
        tot   = (r_acc >>> F) + $signed({{(AW-W){pl_eff[W-1]}}, pl_eff})
                + $signed({{(AW-W){r_rad[W-1]}}, r_rad});
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_p          = r_p;
        n_j          = r_j;
        n_pl_vld     = r_pl_vld;
        n_out_valid  = r_out_valid;
        n_inside_res = r_inside_res;
        n_sq         = r_sq;
        n_len        = r_len;
        n_acc        = r_acc;
        n_inside     = r_inside;
        n_raw_val    = sat_val;
        raw_we       = 1'b0;
        pl_we        = 1'b0;
        pl_wd        = '0;
        mul_a        = {1'b0, mag_j};
        mul_b        = {1'b0, mag_j};
        rd_ctl.start = 1'b0;
        rd_ctl.mode  = RD_ROOT;
        o_in_ready   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_p = '0;
                    n_j = '0;
                    if (i_operation == OP_TEST) begin
                        n_acc    = '0;
                        n_inside = 1'b1;
                        n_state  = S_T_RD;
                    end else if (i_column == 2'd3) begin
                        n_state = S_B_RD;
                    end
                end
            end
            // plane build: raw components
            S_B_RD: n_state = S_B_RAW;
            S_B_RAW: begin
                raw_we = 1'b1;
                if (r_j == 2'd3) begin
                    n_j     = '0;
                    n_sq    = '0;
                    n_state = S_B_MUL;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_B_RD;
                end
            end
            // squared length
            S_B_MUL: n_state = S_B_ACC;
            S_B_ACC: begin
                n_sq = r_sq + mul_p;
                if (r_j == 2'd2) begin
                    n_j     = '0;
                    n_state = S_B_ROOT;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_B_MUL;
                end
            end
            S_B_ROOT: begin
                rd_ctl.start = 1'b1;
                n_state      = S_B_ROOTW;
            end
            S_B_ROOTW: begin
                if (rd_sts.done) begin
                    n_len   = rd_root;
                    n_state = S_B_DIV;
                end
            end
            // normalize each component
            S_B_DIV: begin
                if (r_len == '0) begin
                    pl_we = 1'b1;
                    if (r_j == 2'd3) begin
                        n_j = '0;
                        if (r_p == P_LAST) begin
                            n_p      = '0;
                            n_pl_vld = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_p     = r_p + 3'd1;
                            n_state = S_B_RD;
                        end
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end else begin
                    rd_ctl.start = 1'b1;
                    rd_ctl.mode  = RD_DIV;
                    n_state      = S_B_DIVW;
                end
            end
            S_B_DIVW: begin
                rd_ctl.mode = RD_DIV;
                if (rd_sts.done) begin
                    pl_we = 1'b1;
                    if (q_big) begin
                        pl_wd = cur_raw[W-1] ? WMIN : WMAX;
                    end else begin
                        pl_wd = cur_raw[W-1] ? (~q_lo + W'(1)) : q_lo;
                    end
                    if (r_j == 2'd3) begin
                        n_j = '0;
                        if (r_p == P_LAST) begin
                            n_p      = '0;
                            n_pl_vld = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_p     = r_p + 3'd1;
                            n_state = S_B_RD;
                        end
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = S_B_DIV;
                    end
                end
            end
            // sphere test: dot product per plane
            S_T_RD: n_state = S_T_MUL;
            S_T_MUL: begin
                mul_a   = {pl_eff[W-1], pl_eff};
                mul_b   = {pos_j[W-1], pos_j};
                n_state = S_T_ACC;
            end
            S_T_ACC: begin
                n_acc = r_acc + {{(AW-PW){mul_p[PW-1]}}, mul_p};
                if (r_j == 2'd2) begin
                    n_j     = 2'd3;
                    n_state = S_T_RDD;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_T_RD;
                end
            end
            S_T_RDD: n_state = S_T_CHK;
            S_T_CHK: begin
                if (tot[AW-1]) begin
                    n_inside = 1'b0;
                end
                n_acc = '0;
                n_j   = '0;
                if (r_p == P_LAST) begin
                    n_p     = '0;
                    n_state = S_T_OUT;
                end else begin
                    n_p     = r_p + 3'd1;
                    n_state = S_T_RD;
                end
            end
            S_T_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_inside_res = r_inside;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p         <= '0;
            r_j         <= '0;
            r_mat_vld   <= '0;
            r_pl_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p         <= n_p;
            r_j         <= n_j;
            r_pl_vld    <= n_pl_vld;
            r_out_valid <= n_out_valid;
            if (accept && i_operation == OP_LOAD) begin
                r_mat_vld[i_column] <= 1'b1;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_inside_res <= n_inside_res;
        r_sq         <= n_sq;
        r_len        <= n_len;
        r_acc        <= n_acc;
        r_inside     <= n_inside;
        if (raw_we) begin
            r_raw[r_j] <= n_raw_val;
        end
        if (accept && i_operation == OP_TEST) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_rad    <= i_radius;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside_res;

    // root/divide unit reports completion only to a waiting sequencer
    a_rd_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_sts.done |-> (r_state == S_B_ROOTW || r_state == S_B_DIVW))
        else $error("root/divide done outside a wait state");

    // a test request starts the plane sweep at plane zero
    a_test_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_TEST) |=> (r_state == S_T_RD && r_p == 3'd0))
        else $error("test request did not start the plane sweep");

    // loading column 3 starts a plane build
    a_build_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_LOAD && i_column == 2'd3) |=> (r_state == S_B_RD))
        else $error("column 3 load did not start a plane build");

    // plane index never exceeds the last plane
    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_p <= P_LAST))
        else $error("plane index out of range");

endmodule
